// ===== sv/table_linear_interpolation_defines.svh =====
// Assertion macros used by the checker of the table interpolation block.
// No dependencies; include with the bare file name.
`ifndef TABLE_LINEAR_INTERPOLATION_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATION_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define TLI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tli: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define TLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tli: next-cycle check failed");

`endif

// ===== sv/tli_pkg.sv =====
// Shared constants, codes, types and helpers of the table interpolation block.
// No dependencies; used by the datapath, the multiply-divide unit and the checker.
package tli_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam int CFG_W    = 7;
    localparam int IDX_W    = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Differences of two 32-bit values need one extra bit.
    localparam int MAG_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int STEP_W = $clog2(MAG_W);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] RANGE_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] RANGE_FIRST  = 2'd1;
    localparam logic [STATUS_W-1:0] RANGE_LAST   = 2'd2;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag_a;
        logic [MAG_W-1:0] mag_b;
        logic [MAG_W-1:0] mag_d;
    } md_req_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] v);
        logic [MAG_W-1:0] neg_v;
        neg_v = MAG_W'(~v + 1'b1);
        return v[MAG_W-1] ? neg_v : v;
    endfunction

endpackage

// ===== sv/tli_mul_div.sv =====
// Serial unit computing floor(a * b / d) on unsigned magnitudes.
// Depends on tli_pkg; one shift-add multiply then one restoring divide.
module tli_mul_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tli_pkg::md_req_t          md_req,
    output logic                      md_done,
    output logic [tli_pkg::MAG_W-1:0] md_quotient
);

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

    md_state_t                       md_state_reg;
    logic [tli_pkg::STEP_W-1:0]      cnt_reg;
    logic [tli_pkg::PROD_W-1:0]      acc_reg;
    logic [tli_pkg::MAG_W-1:0]       a_reg;
    logic [tli_pkg::MAG_W-1:0]       d_reg;
    logic                            done_reg;

    logic [tli_pkg::MAG_W:0]         mul_sum;
    logic [tli_pkg::PROD_W-1:0]      mul_next;
    logic [tli_pkg::MAG_W:0]         div_trial;
    logic [tli_pkg::MAG_W:0]         div_diff;
    logic                            div_ge;
    logic [tli_pkg::PROD_W-1:0]      div_next;
    logic                            last_step;

    always_comb begin
        // Multiply: add multiplicand into the upper half, then shift right.
        mul_sum  = {1'b0, acc_reg[tli_pkg::PROD_W-1:tli_pkg::MAG_W]}
                 + (acc_reg[0] ? {1'b0, a_reg} : '0);
        mul_next = {mul_sum, acc_reg[tli_pkg::MAG_W-1:1]};
        // Divide: remainder sits in the upper half, quotient bits enter at the bottom.
        div_trial = {acc_reg[tli_pkg::PROD_W-1:tli_pkg::MAG_W], acc_reg[tli_pkg::MAG_W-1]};
        div_ge    = div_trial >= {1'b0, d_reg};
        div_diff  = div_trial - {1'b0, d_reg};
        div_next  = {(div_ge ? div_diff[tli_pkg::MAG_W-1:0] : div_trial[tli_pkg::MAG_W-1:0]),
                     acc_reg[tli_pkg::MAG_W-2:0], div_ge};
        last_step = cnt_reg == tli_pkg::STEP_W'(tli_pkg::MAG_W - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            md_state_reg <= MD_IDLE;
            done_reg     <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (md_state_reg)
                MD_IDLE: begin
                    if (md_req.start) begin
                        acc_reg      <= {tli_pkg::MAG_W'(0), md_req.mag_b};
                        a_reg        <= md_req.mag_a;
                        d_reg        <= md_req.mag_d;
                        cnt_reg      <= '0;
                        md_state_reg <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    acc_reg <= mul_next;
                    if (last_step) begin
                        cnt_reg      <= '0;
                        md_state_reg <= MD_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                MD_DIV: begin
                    acc_reg <= div_next;
                    if (last_step) begin
                        done_reg     <= 1'b1;
                        md_state_reg <= MD_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: begin
                    md_state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    assign md_done     = done_reg;
    assign md_quotient = acc_reg[tli_pkg::MAG_W-1:0];

endmodule

// ===== sv/table_linear_interpolation.sv =====
// Piecewise-linear table interpolation, top level.
// Input channel s_*: write items (s_operation = 0) store one (x, y) point at
// s_entry_index; lookup items (s_operation = 1) convert s_sample from the y axis
// to the x axis. Result channel m_*: one item per lookup, none per write.
// cfg_we / cfg_wdata set table_size, the number of points a lookup walks (at most 64).
// A write item is stored at acceptance. A lookup reads the first two y points to find
// the table direction, then walks y one entry per cycle from the y memory port
// until it stops at index k (k <= table_size). A clamped result takes the x point
// at that table end; an interpolated one goes through the serial unit: 33 shift-add
// steps for the product, then 33 restoring divide steps.
// One lookup is in work at a time; s_ready is high whenever no lookup is active.
// A finished result sits in the output register, so the next item is taken while
// the receiver stalls; a further lookup then waits for that register to empty.
// Reset empties the output register and sets table_size to 1. Point storage is
// not cleared: every point a lookup reaches must have been written first.
// Depends on tli_pkg and tli_mul_div.
module table_linear_interpolation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tli_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [tli_pkg::IDX_W-1:0]           s_entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]   s_entry_x,
    input  logic signed [tli_pkg::DATA_W-1:0]   s_entry_y,
    input  logic signed [tli_pkg::DATA_W-1:0]   s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tli_pkg::DATA_W-1:0]   m_result_value,
    output logic [tli_pkg::STATUS_W-1:0]        m_range_status
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIR_A, ST_DIR_B, ST_WALK, ST_X0, ST_X1, ST_X2, ST_MULDIV, ST_DONE
    } state_t;

    // Point memories
    logic signed [tli_pkg::DATA_W-1:0] x_mem [tli_pkg::TABLE_DEPTH];
    logic signed [tli_pkg::DATA_W-1:0] y_mem [tli_pkg::TABLE_DEPTH];
    logic signed [tli_pkg::DATA_W-1:0] x_q_reg;
    logic signed [tli_pkg::DATA_W-1:0] y_q_reg;
    logic [tli_pkg::ADDR_W-1:0]        x_rd_addr;
    logic [tli_pkg::ADDR_W-1:0]        y_rd_addr;
    logic [tli_pkg::ADDR_W-1:0]        wr_addr;
    logic                              wr_en;

    // Control and datapath registers
    state_t                            state_reg;
    logic [tli_pkg::CFG_W-1:0]         table_size_reg;
    logic [tli_pkg::CNT_W-1:0]         n_reg;
    logic [tli_pkg::CNT_W-1:0]         n_next;
    logic signed [tli_pkg::DATA_W-1:0] sample_reg;
    logic signed [tli_pkg::DATA_W-1:0] y0_reg;
    logic signed [tli_pkg::DATA_W-1:0] y_prev_reg;
    logic signed [tli_pkg::DATA_W-1:0] x_lo_reg;
    logic                              desc_reg;
    logic [tli_pkg::CNT_W-1:0]         walk_idx_reg;
    logic [tli_pkg::CNT_W-1:0]         idx_reg;
    logic [tli_pkg::STATUS_W-1:0]      status_reg;
    logic [tli_pkg::MAG_W-1:0]         mag_t_reg;
    logic [tli_pkg::MAG_W-1:0]         mag_d_reg;
    logic                              neg_reg;
    logic [tli_pkg::DATA_W-1:0]        res_value_reg;
    logic [tli_pkg::STATUS_W-1:0]      res_status_reg;
    logic                              m_valid_reg;
    logic [tli_pkg::DATA_W-1:0]        m_result_value_reg;
    logic [tli_pkg::STATUS_W-1:0]      m_range_status_reg;

    // Walk and arithmetic helpers
    logic                              s_accept;
    logic                              out_load;
    logic                              past_end;
    logic                              hit;
    logic [tli_pkg::STATUS_W-1:0]      stop_status;
    logic [tli_pkg::MAG_W-1:0]         t_diff;
    logic [tli_pkg::MAG_W-1:0]         d_diff;
    logic [tli_pkg::MAG_W-1:0]         dx_diff;
    logic [tli_pkg::DATA_W-1:0]        q_low;
    logic [tli_pkg::DATA_W-1:0]        offset;
    logic [tli_pkg::DATA_W-1:0]        interp_value;

    tli_pkg::md_req_t                  md_req;
    logic                              md_done;
    logic [tli_pkg::MAG_W-1:0]         md_quotient;

    assign s_ready  = state_reg == ST_IDLE;
    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign wr_addr = tli_pkg::ADDR_W'(s_entry_index);
    assign wr_en   = s_accept && (s_operation == tli_pkg::OP_WRITE)
                   && (32'(s_entry_index) < 32'(tli_pkg::TABLE_DEPTH));

    always_comb begin
        if (32'(table_size_reg) > 32'(tli_pkg::TABLE_DEPTH)) begin
            n_next = tli_pkg::CNT_W'(tli_pkg::TABLE_DEPTH);
        end else begin
            n_next = tli_pkg::CNT_W'(table_size_reg);
        end
    end

    // y port: direction points first, then one entry ahead of the walk
    always_comb begin
        case (state_reg)
            ST_DIR_A: y_rd_addr = tli_pkg::ADDR_W'(1);
            ST_WALK:  y_rd_addr = tli_pkg::ADDR_W'(walk_idx_reg + 1'b1);
            default:  y_rd_addr = '0;
        endcase
    end

    // x port: one clamp point, or the left then the right neighbor
    always_comb begin
        case (state_reg)
            ST_X0: begin
                if (status_reg == tli_pkg::RANGE_LAST) begin
                    x_rd_addr = tli_pkg::ADDR_W'(n_reg - 1'b1);
                end else if (status_reg == tli_pkg::RANGE_INTERP) begin
                    x_rd_addr = tli_pkg::ADDR_W'(idx_reg - 1'b1);
                end else begin
                    x_rd_addr = '0;
                end
            end
            ST_X1:   x_rd_addr = tli_pkg::ADDR_W'(idx_reg);
            default: x_rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= s_entry_x;
            y_mem[wr_addr] <= s_entry_y;
        end
        x_q_reg <= x_mem[x_rd_addr];
        y_q_reg <= y_mem[y_rd_addr];
    end

    always_comb begin
        past_end = walk_idx_reg >= n_reg;
        hit      = desc_reg ? (y_q_reg < sample_reg) : (y_q_reg > sample_reg);
        if (walk_idx_reg == '0) begin
            stop_status = tli_pkg::RANGE_FIRST;
        end else if (past_end) begin
            stop_status = tli_pkg::RANGE_LAST;
        end else begin
            stop_status = tli_pkg::RANGE_INTERP;
        end
        t_diff  = {sample_reg[tli_pkg::DATA_W-1], sample_reg}
                - {y_prev_reg[tli_pkg::DATA_W-1], y_prev_reg};
        d_diff  = {y_q_reg[tli_pkg::DATA_W-1], y_q_reg}
                - {y_prev_reg[tli_pkg::DATA_W-1], y_prev_reg};
        dx_diff = {x_q_reg[tli_pkg::DATA_W-1], x_q_reg}
                - {x_lo_reg[tli_pkg::DATA_W-1], x_lo_reg};
        q_low        = md_quotient[tli_pkg::DATA_W-1:0];
        offset       = neg_reg ? (~q_low + 1'b1) : q_low;
        interp_value = x_lo_reg + offset;
    end

    always_comb begin
        md_req.start = state_reg == ST_X2;
        md_req.mag_a = tli_pkg::mag_of(dx_diff);
        md_req.mag_b = mag_t_reg;
        md_req.mag_d = mag_d_reg;
    end

    tli_mul_div u_mul_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .md_req      (md_req),
        .md_done     (md_done),
        .md_quotient (md_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            table_size_reg <= tli_pkg::CFG_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                table_size_reg <= cfg_wdata;
            end
            // Load a finished lookup, else drop the item the receiver took
            if (out_load) begin
                m_valid_reg        <= 1'b1;
                m_result_value_reg <= res_value_reg;
                m_range_status_reg <= res_status_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && s_operation == tli_pkg::OP_LOOKUP) begin
                        sample_reg <= s_sample;
                        n_reg      <= n_next;
                        state_reg  <= ST_DIR_A;
                    end
                end
                ST_DIR_A: begin
                    y0_reg    <= y_q_reg;
                    state_reg <= ST_DIR_B;
                end
                ST_DIR_B: begin
                    // Descending unless the table has two or more points and the second rises above the first
                    desc_reg     <= !((n_reg > tli_pkg::CNT_W'(1)) && (y0_reg < y_q_reg));
                    walk_idx_reg <= '0;
                    state_reg    <= ST_WALK;
                end
                ST_WALK: begin
                    if (past_end || hit) begin
                        idx_reg    <= walk_idx_reg;
                        status_reg <= stop_status;
                        mag_t_reg  <= tli_pkg::mag_of(t_diff);
                        mag_d_reg  <= tli_pkg::mag_of(d_diff);
                        state_reg  <= ST_X0;
                    end else begin
                        y_prev_reg   <= y_q_reg;
                        walk_idx_reg <= walk_idx_reg + 1'b1;
                    end
                end
                ST_X0: begin
                    state_reg <= ST_X1;
                end
                ST_X1: begin
                    if (status_reg != tli_pkg::RANGE_INTERP) begin
                        res_value_reg  <= x_q_reg;
                        res_status_reg <= status_reg;
                        state_reg      <= ST_DONE;
                    end else begin
                        x_lo_reg  <= x_q_reg;
                        state_reg <= ST_X2;
                    end
                end
                ST_X2: begin
                    neg_reg   <= dx_diff[tli_pkg::MAG_W-1];
                    state_reg <= ST_MULDIV;
                end
                ST_MULDIV: begin
                    if (md_done) begin
                        res_value_reg  <= interp_value;
                        res_status_reg <= tli_pkg::RANGE_INTERP;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = $signed(m_result_value_reg);
    assign m_range_status = m_range_status_reg;

endmodule

// ===== sv/tli_checker.sv =====
// Port-level checker for the table interpolation block, bound to the top level.
// Depends on tli_pkg and table_linear_interpolation_defines.svh.
`include "table_linear_interpolation_defines.svh"

module tli_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_operation,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [tli_pkg::DATA_W-1:0]   m_result_value,
    input logic [tli_pkg::STATUS_W-1:0]        m_range_status
);

    logic                                         write_take;
    logic                                         lookup_take;
    logic                                         m_stall;
    logic                                         status_known;
    logic [tli_pkg::DATA_W+tli_pkg::STATUS_W-1:0] m_payload;

    assign write_take   = s_valid && s_ready && (s_operation == tli_pkg::OP_WRITE);
    assign lookup_take  = s_valid && s_ready && (s_operation == tli_pkg::OP_LOOKUP);
    assign m_stall      = m_valid && !m_ready;
    assign status_known = m_range_status inside {tli_pkg::RANGE_INTERP, tli_pkg::RANGE_FIRST,
                                                 tli_pkg::RANGE_LAST};
    assign m_payload    = {m_result_value, m_range_status};

    // A stalled result item holds
    `TLI_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_stall, m_valid && $stable(m_payload))

    `TLI_ASSERT_IMPLY(a_status_code, aclk, aresetn, m_valid, status_known)

    // A write item never produces a result
    `TLI_ASSERT_NEXT(a_write_silent, aclk, aresetn, write_take && !m_valid, !m_valid)

    // A lookup occupies the block: no item taken right after it, no instant result
    `TLI_ASSERT_NEXT(a_lookup_busy, aclk, aresetn, lookup_take, !s_ready && !$rose(m_valid))

endmodule

bind table_linear_interpolation tli_checker u_tli_checker (.*);
